// ===== hdl/sn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// sn2d_pkg: shared types and constants for the 2D simplex noise pixel block
// Holds the transaction structs, hash constants, skew constants and the
// gradient table function.
// ----------------------------------------------------------------------------
`default_nettype none
package sn2d_pkg;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] noise_value;
    logic        saturated;
  } pix_out_t;

  localparam logic [31:0] HASH_MUL_A   = 32'h9E3779B9;
  localparam logic [31:0] HASH_MUL_B   = 32'h85EBCA6B;
  localparam logic [31:0] SEED_MUL     = 32'h045D9F3B;
  localparam logic [31:0] F2_Q32       = 32'd1572067139;
  localparam logic [31:0] G2_Q32       = 32'd907633386;
  localparam logic [21:0] OUT_GAIN_Q16 = 22'd3042968;

  localparam logic [0:0] REG_FREQUENCY = 1'b0;
  localparam logic [0:0] REG_SEED      = 1'b1;

  // Gradient magnitude a^2*65536/(8192-a^2), rounded, for a in 0..64 (Q2.16).
  function automatic logic [17:0] grad_entry(input logic [6:0] a);
    logic [25:0] a2;
    logic [25:0] den;
    logic [41:0] num;
    a2  = 26'(a) * 26'(a);
    den = 26'd8192 - a2;
    num = (42'(a2) << 16) + 42'(den >> 1);
    return 18'(num / 42'(den));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sn2d_corner.sv =====
// ----------------------------------------------------------------------------
// sn2d_corner: pipelined hash and contribution of one simplex corner
// Seven register stages: first hash multiply, second hash multiply, gradient
// and squared distance, falloff squared with dot product, dot scaling,
// falloff to the fourth, final product.
// ----------------------------------------------------------------------------
`default_nettype none
module sn2d_corner import sn2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic [31:0]           seed_mix,
  input  wire logic [31:0]           ci,
  input  wire logic [31:0]           cj,
  input  wire logic signed [FRAC_BITS+2:0] dx,
  input  wire logic signed [FRAC_BITS+2:0] dy,
  output logic signed [FRAC_BITS+24:0]     contrib
);

  localparam int DW = FRAC_BITS + 3;
  localparam int MW = FRAC_BITS;

  // Stage 1: first multiply of the hash.
  logic [31:0] h1, cj1, sm1;
  logic signed [DW-1:0] dx1, dy1;
  // Stage 2: second multiply.
  logic [31:0] h2;
  logic signed [DW-1:0] dx2, dy2;
  // Stage 3: gradient and squared distance.
  logic signed [18:0] ca3, sa3;
  logic signed [DW-1:0] dx3, dy3;
  logic [2*DW-1:0] d2sum3;
  // Stage 4: falloff and dot.
  logic [MW-1:0] m4s;
  logic signed [DW+19:0] dot4;
  // Stage 5: m squared.
  logic [MW-1:0] m2s5;
  logic signed [DW+3:0] dotq5;
  // Stage 6: m^4.
  logic [MW-1:0] m4s6;
  logic signed [DW+3:0] dotq6;

  logic [31:0] hx, hm;
  logic [6:0]  o;
  logic [2*DW-1:0] d2;
  logic signed [MW+1:0] mraw;
  logic [2*MW-1:0] msq, m2sq;

  // Gradient magnitudes for a in 0..64, built once from constants.
  logic [17:0] grad_tab [65];
  for (genvar a = 0; a < 65; a++) begin : g_grad
    localparam logic [17:0] GRAD = grad_entry(7'(a));
    assign grad_tab[a] = GRAD;
  end

  always_comb begin
    hx  = h1 ^ cj1 ^ sm1;
    hx  = hx ^ (hx >> 16);
  end

  always_comb begin
    hm = h2 ^ (h2 >> 13);
    o  = {1'b0, hm[5:0]};
  end

  always_comb begin
    d2   = d2sum3 >> FRAC_BITS;
    mraw = (MW+2)'(1 << (FRAC_BITS - 1)) -
           ((d2 > (2*DW)'(1 << FRAC_BITS)) ? (MW+2)'(1 << FRAC_BITS) : (MW+2)'(d2));
  end

  logic [MW-1:0] mval;
  assign mval = mraw[MW+1] ? MW'(0) : mraw[MW-1:0];
  assign msq  = (2*MW)'(mval) * (2*MW)'(mval);
  assign m2sq = (2*MW)'(m2s5) * (2*MW)'(m2s5);

  always_ff @(posedge clk) begin
    h1  <= ci * HASH_MUL_A;
    cj1 <= cj;
    sm1 <= seed_mix;
    dx1 <= dx;
    dy1 <= dy;

    h2  <= hx * HASH_MUL_B;
    dx2 <= dx1;
    dy2 <= dy1;

    ca3 <= (hm[8] ^ hm[6]) ? -19'(grad_tab[7'd64 - o]) : 19'(grad_tab[7'd64 - o]);
    sa3 <= hm[7] ? -19'(grad_tab[o]) : 19'(grad_tab[o]);
    dx3 <= dx2;
    dy3 <= dy2;
    d2sum3 <= (2*DW)'(dx2) * (2*DW)'(dx2) + (2*DW)'(dy2) * (2*DW)'(dy2);

    m4s  <= MW'(msq >> FRAC_BITS);
    dot4 <= (DW+20)'(ca3) * (DW+20)'(dx3) + (DW+20)'(sa3) * (DW+20)'(dy3);

    m2s5  <= m4s;
    dotq5 <= (DW+4)'(dot4 >>> 16);

    m4s6  <= MW'(m2sq >> FRAC_BITS);
    dotq6 <= dotq5;

    contrib <= ((FRAC_BITS+25)'($signed({1'b0, m4s6})) * (FRAC_BITS+25)'(dotq6))
               >>> FRAC_BITS;
  end

endmodule
`default_nettype wire

// ===== hdl/simplex_noise_2d_pixel.sv =====
// ----------------------------------------------------------------------------
// simplex_noise_2d_pixel: streaming 2D simplex noise, one pixel per clock
// Scales, skews and hashes a pixel coordinate and sums three corner
// contributions into a saturated Q0.16 value.
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  in       | start, busy, pix_in              | accepted when start && !busy
//  out      | done, pix_out                    | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_index, cfg_data      | write on cfg_we
//
// A transaction can enter every cycle; busy is always low. Its result
// appears on done after the skew path (scale multiply, skew multiply,
// cell, unskew, corner offsets), the seven-stage corner unit and the
// output stage. Reset is synchronous and clears only the valid bits and
// the registers; payload stages carry no reset. The receiver cannot
// stall, so nothing is ever held.
`default_nettype none
module simplex_noise_2d_pixel import sn2d_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire pix_in_t     pix_in,
  output logic             done,
  output pix_out_t         pix_out,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int LAT = 13;
  localparam int SW  = COORD_BITS + 24 + FRAC_BITS - 16;  // scaled coordinate width
  localparam int PW  = COORD_BITS + 24 + FRAC_BITS;       // scale product before shift
  localparam int DW  = FRAC_BITS + 3;
  localparam int NW  = FRAC_BITS + 2;                     // corner sum width

  logic [23:0] frequency;
  logic [31:0] seed;
  logic [31:0] seed_mix;
  logic [LAT-1:0] vld;

  // Configuration registers; seed's multiply is precomputed here.
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency <= 24'd2621;
      seed      <= 32'd42;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQUENCY: frequency <= cfg_data[23:0];
        REG_SEED:      seed      <= cfg_data;
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk) seed_mix <= seed * SEED_MUL;

  assign busy = 1'b0;

  // Stage 1: scale.
  logic [COORD_BITS-1:0] px, py;
  logic [SW-1:0] sx1, sy1;
  assign px = COORD_BITS'(pix_in.pixel_x);
  assign py = COORD_BITS'(pix_in.pixel_y);

  // Stage 2: skew factor.
  logic [SW-1:0] sx2, sy2;
  logic [SW+32:0] s2prod;
  // Stage 3: cell.
  logic [SW-1:0] sx3, sy3;
  logic [31:0] fi3, fj3;
  // Stage 4: unskew.
  logic [SW-1:0] sx4, sy4;
  logic [31:0] fi4, fj4;
  logic [SW+32:0] t2prod;

  logic [SW-1:0] s2;
  assign s2 = SW'(s2prod >> 32);

  logic [SW:0] sumx, sumy;
  assign sumx = (SW+1)'(sx2) + (SW+1)'(s2);
  assign sumy = (SW+1)'(sy2) + (SW+1)'(s2);

  always_ff @(posedge clk) begin
    sx1 <= SW'((PW'((COORD_BITS+24)'(px) * (COORD_BITS+24)'(frequency)) << FRAC_BITS) >> 16);
    sy1 <= SW'((PW'((COORD_BITS+24)'(py) * (COORD_BITS+24)'(frequency)) << FRAC_BITS) >> 16);
    sx2 <= sx1;
    sy2 <= sy1;
    s2prod <= ((SW+33)'(sx1) + (SW+33)'(sy1)) * (SW+33)'(F2_Q32);
    sx3 <= sx2;
    sy3 <= sy2;
    fi3 <= 32'(sumx >> FRAC_BITS);
    fj3 <= 32'(sumy >> FRAC_BITS);
    sx4 <= sx3;
    sy4 <= sy3;
    fi4 <= fi3;
    fj4 <= fj3;
    // The lattice sum carries FRAC_BITS zero fraction bits, folded into the shift.
    t2prod <= ((SW+33)'(fi3) + (SW+33)'(fj3)) * (SW+33)'(G2_Q32);
  end

  // Stage 5: corner offsets.
  localparam logic signed [DW-1:0] ONE  = DW'(1 << FRAC_BITS);
  localparam logic signed [DW-1:0] G2F  = DW'(G2_Q32 >> (32 - FRAC_BITS));
  localparam logic signed [DW-1:0] G2X2 = DW'((33'(G2_Q32) * 2) >> (32 - FRAC_BITS));
  logic signed [DW-1:0] x0, y0;
  logic [SW-1:0] t2;
  assign t2 = SW'(t2prod >> (32 - FRAC_BITS));
  assign x0 = DW'($signed({1'b0, sx4}) - $signed({1'b0, SW'(fi4) << FRAC_BITS})
              + $signed({1'b0, t2}));
  assign y0 = DW'($signed({1'b0, sy4}) - $signed({1'b0, SW'(fj4) << FRAC_BITS})
              + $signed({1'b0, t2}));

  logic [31:0] c_ci [3];
  logic [31:0] c_cj [3];
  logic signed [DW-1:0] c_dx [3];
  logic signed [DW-1:0] c_dy [3];
  logic signed [FRAC_BITS+24:0] c_ct [3];
  logic i1;
  assign i1 = x0 > y0;

  always_ff @(posedge clk) begin
    c_ci[0] <= fi4;          c_cj[0] <= fj4;
    c_dx[0] <= x0;           c_dy[0] <= y0;
    c_ci[1] <= fi4 + 32'(i1); c_cj[1] <= fj4 + 32'(!i1);
    c_dx[1] <= x0 - (i1 ? ONE : '0) + G2F;
    c_dy[1] <= y0 - (i1 ? '0 : ONE) + G2F;
    c_ci[2] <= fi4 + 32'd1;  c_cj[2] <= fj4 + 32'd1;
    c_dx[2] <= x0 - ONE + G2X2;
    c_dy[2] <= y0 - ONE + G2X2;
  end

  // Stages 6 to 12: three corner units side by side.
  for (genvar k = 0; k < 3; k++) begin : g_corner
    sn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
      .clk(clk), .seed_mix(seed_mix), .ci(c_ci[k]), .cj(c_cj[k]),
      .dx(c_dx[k]), .dy(c_dy[k]), .contrib(c_ct[k])
    );
  end

  // Stage 13: sum, gain, round and saturate. Each corner adds at most a
  // sixteenth of one unit, so the sum fits in FRAC_BITS + 2 signed bits.
  logic signed [NW-1:0] nsum;
  logic signed [NW+24:0] rsc;
  logic signed [NW+24:0] r;
  assign nsum = NW'(c_ct[0]) + NW'(c_ct[1]) + NW'(c_ct[2]);
  assign rsc  = nsum * $signed({1'b0, OUT_GAIN_Q16}) + (NW+25)'(1 << (FRAC_BITS - 1));
  assign r    = (rsc >>> FRAC_BITS) + (NW+25)'(32768);

  always_ff @(posedge clk) begin
    if (r < 0) begin
      pix_out.noise_value <= 16'd0;
      pix_out.saturated   <= 1'b1;
    end else if (r > 65535) begin
      pix_out.noise_value <= 16'hFFFF;
      pix_out.saturated   <= 1'b1;
    end else begin
      pix_out.noise_value <= r[15:0];
      pix_out.saturated   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-2:0], start && !busy};
  end
  assign done = vld[LAT-1];

  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT) done) else $error("result lost");
  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    done && pix_out.saturated |-> pix_out.noise_value == 16'd0 ||
    pix_out.noise_value == 16'hFFFF) else $error("saturation value");

endmodule
`default_nettype wire

// ===== tb/sv/simplex_noise_2d_pixel_test.sv =====
// ----------------------------------------------------------------------------
// simplex_noise_2d_pixel_test: self-checking bench for the simplex noise block
// Drives pixel coordinates under several frequency and seed settings, computes
// the expected noise value and saturation flag for each one, and compares
// every result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module simplex_noise_2d_pixel_test;
  import sn2d_pkg::*;

  localparam int FRAC  = 16;
  localparam int LAT   = 13;
  localparam int WDOG  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pix_in_t     pix_in = '0;
  logic        done;
  pix_out_t    pix_out;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_FREQUENCY;
  logic [31:0] cfg_data = '0;

  simplex_noise_2d_pixel u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pix_in(pix_in),
    .done(done), .pix_out(pix_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Bench copy of the configuration registers.
  logic [23:0] freq_q = 24'd2621;
  logic [31:0] seed_q = 32'd42;

  pix_in_t  pixel_queue[$];
  pix_out_t noise_expected[$];
  int       send_idle_pct = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       timed_out = 1'b0;

  // Magnitude of a gradient component in Q2.16: a^2*65536/(8192-a^2) rounded.
  function automatic longint grad_mag(int unsigned a);
    longint a2;
    longint den;
    a2 = longint'(a) * a;
    den = 8192 - a2;
    return ((a2 << 16) + den / 2) / den;
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] a, logic [31:0] b);
    logic [31:0] h;
    h = a * HASH_MUL_A;
    h ^= b ^ (seed_q * SEED_MUL);
    h ^= h >> 16;
    h *= HASH_MUL_B;
    h ^= h >> 13;
    return h;
  endfunction

  // Multiply by a Q0.32 constant, dropping the fraction exactly like the
  // block does (split into high and low 32-bit halves).
  function automatic longint scale_q32(longint v, longint k);
    return (v >>> 32) * k + (((v & 64'hFFFF_FFFF) * k) >>> 32);
  endfunction

  function automatic longint corner_term(logic [31:0] h, longint dx, longint dy);
    longint ca, sa, d2, m, m2, m4, dot;
    ca = grad_mag(64 - (h & 32'h3F));
    sa = grad_mag(h & 32'h3F);
    if (h[8] ^ h[6]) ca = -ca;
    if (h[7]) sa = -sa;
    d2 = (dx * dx + dy * dy) >>> FRAC;
    m = (longint'(1) << (FRAC - 1)) - d2;
    if (m < 0) m = 0;
    m2 = (m * m) >>> FRAC;
    m4 = (m2 * m2) >>> FRAC;
    dot = (ca * dx + sa * dy) >>> 16;
    return (m4 * dot) >>> FRAC;
  endfunction

  function automatic pix_out_t noise_of(pix_in_t p);
    longint sx, sy, s2, fi, fj, t2, g2, g2x2, x0, y0, x1, y1, x2, y2, n, r;
    longint one;
    logic [31:0] ci, cj;
    bit i1;
    pix_out_t o;
    one = longint'(1) << FRAC;
    sx = longint'(p.pixel_x) * freq_q;
    sy = longint'(p.pixel_y) * freq_q;
    s2 = scale_q32(sx + sy, longint'(F2_Q32));
    fi = (sx + s2) >>> FRAC;
    fj = (sy + s2) >>> FRAC;
    t2 = scale_q32((fi + fj) << FRAC, longint'(G2_Q32));
    g2 = longint'(G2_Q32) >>> (32 - FRAC);
    g2x2 = (longint'(G2_Q32) * 2) >>> (32 - FRAC);
    x0 = sx - (fi << FRAC) + t2;
    y0 = sy - (fj << FRAC) + t2;
    i1 = x0 > y0;
    x1 = x0 - (i1 ? one : 0) + g2;
    y1 = y0 - (i1 ? 0 : one) + g2;
    x2 = x0 - one + g2x2;
    y2 = y0 - one + g2x2;
    ci = fi[31:0];
    cj = fj[31:0];
    n = corner_term(lattice_hash(ci, cj), x0, y0)
      + corner_term(lattice_hash(ci + i1, cj + !i1), x1, y1)
      + corner_term(lattice_hash(ci + 1, cj + 1), x2, y2);
    r = ((n * longint'(OUT_GAIN_Q16) + (longint'(1) << (FRAC - 1))) >>> FRAC) + 32768;
    o.saturated = 1'b0;
    if (r < 0) begin
      r = 0;
      o.saturated = 1'b1;
    end else if (r > 65535) begin
      r = 65535;
      o.saturated = 1'b1;
    end
    o.noise_value = r[15:0];
    return o;
  endfunction

  // Driver: offers queued pixels, idling at random. start only changes once
  // per edge, so a back-to-back stream keeps it high.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) noise_expected.push_back(noise_of(pix_in));
      if ((!start || !busy) && pixel_queue.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        pix_in <= pixel_queue.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe is one result transaction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", pix_out);
      end else begin
        pix_out_t e;
        e = noise_expected.pop_front();
        if (e.noise_value !== pix_out.noise_value || e.saturated !== pix_out.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h sat %b, got value %h sat %b",
                     e.noise_value, e.saturated, pix_out.noise_value, pix_out.saturated);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || pixel_queue.size() == 0 && noise_expected.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) timed_out <= 1'b1;
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FREQUENCY) freq_q = val[23:0];
    else seed_q = val;
  endtask

  // Wait until the pipeline has drained before touching the registers.
  task automatic drain;
    while ((pixel_queue.size() > 0 || start || noise_expected.size() > 0) && !timed_out)
      @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  task automatic add_pixel(logic [11:0] x, logic [11:0] y);
    pix_in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    pixel_queue.push_back(p);
  endtask

  // Random pixels: mostly small coordinates around a tile, with some full-range.
  task automatic add_random(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0) add_pixel(12'($urandom), 12'($urandom));
      else add_pixel(12'($urandom_range(255)), 12'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [23:0] freqs[6];
    freqs = '{24'd2621, 24'd0, 24'hFFFFFF, 24'd65536, 24'd700, 24'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: corners of the coordinate range and two alternating bit patterns, at reset settings.
    add_pixel(12'd0, 12'd0);
    add_pixel(12'hFFF, 12'd0);
    add_pixel(12'd0, 12'hFFF);
    add_pixel(12'hFFF, 12'hFFF);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(12'h555, 12'hAAA);
    drain();
    // High frequency and all-ones seed to drive the output into saturation.
    write_reg(REG_FREQUENCY, 32'd40000);
    write_reg(REG_SEED, 32'hFFFFFFFF);
    for (int k = 0; k < 14; k++) add_pixel(12'(k * 3), 12'(k * 5 + 1));
    drain();
    for (int ph = 0; ph < 6 && !timed_out; ph++) begin
      send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 64 : 0;
      write_reg(REG_FREQUENCY, (ph == 5) ? $urandom_range(24'hFFFFFF) : freqs[ph]);
      write_reg(REG_SEED, (ph == 1) ? 32'd0 : $urandom);
      add_random(290);
      drain();
    end
    if (timed_out) begin
      $display("[simplex_noise_2d_pixel] ERROR");
      $finish;
    end else if (mismatches == 0) begin
      $display("[simplex_noise_2d_pixel] OK");
      $finish;
    end else begin
      $display("[simplex_noise_2d_pixel] ERROR");
      $finish;
    end
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/sn2d_pkg.sv
hdl/sn2d_corner.sv
hdl/simplex_noise_2d_pixel.sv
tb/sv/simplex_noise_2d_pixel_test.sv
